[hdl/byte_weighted_lru_directory_core_assert.svh]
// assertion macros for the byte-weighted lru directory
// relies on clk and arst_n being visible where the macros are used
`ifndef BYTE_WEIGHTED_LRU_DIRECTORY_CORE_ASSERT_SVH
`define BYTE_WEIGHTED_LRU_DIRECTORY_CORE_ASSERT_SVH
// same-cycle implication
`define BWLD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BWLD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hdl/bwld_pkg.sv]
// shared types and constants of the byte-weighted lru directory
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bwld_pkg;
	localparam int KEY_PORT_W = 64;
	localparam int HDL_PORT_W = 16;
	localparam int LEN_W      = 32;
	localparam int BUDGET_W   = 35;
	localparam logic [LEN_W-1:0] CAP_RESET = 32'd1048576;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_PROBE = 2'd1,
		OP_GET   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_FULLEVICT,
		ST_INSERT,
		ST_EVICT,
		ST_STATUS
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic lookup;
		logic update;
		logic insert;
		logic evict;
		logic status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_put;
		logic match;
		logic oversize;
		logic full;
		logic need_evict;
	} stat_t;

	// free budget clipped to the 32-bit report range
	function automatic logic [LEN_W-1:0] sat_free(input logic signed [BUDGET_W-1:0] b);
		logic [LEN_W-1:0] r;
		if (b < 0)
			r = '0;
		else if (b > $signed({{(BUDGET_W-LEN_W){1'b0}}, {LEN_W{1'b1}}}))
			r = '1;
		else
			r = b[LEN_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

[hdl/byte_weighted_lru_directory_core.sv]
// top level of the byte-weighted lru directory: sequencer plus datapath
// uses bwld_pkg, bwld_ctrl, bwld_datapath and the assertion macro header
//
// channel   handshake                 payload
// item in   start, busy               op, key_tag, response_handle, content_length
// config    cfg_valid, cfg_ready      cfg_data (capacity_bytes)
// result    strobe (one cycle)        kind, hit, result_key, result_handle,
//                                     free_bytes, last
//
// probe and get go from lookup straight to status. a put passes lookup,
// then update or insert, then eviction and status; a new key that fits
// into a full table first drops its oldest entry. a put of a new key larger
// than the capacity skips the store and goes from lookup straight to eviction.
// eviction walks the recency ranks one entry per cycle. reset clears all
// valid bits at once, no clearing pass. results cannot be stalled; cfg_ready
// is high only while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_weighted_lru_directory_core_assert.svh"
module byte_weighted_lru_directory_core
	import bwld_pkg::*;
#(
	parameter int ENTRIES     = 16,
	parameter int KEY_BITS    = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            op,
	input  wire logic [KEY_PORT_W-1:0] key_tag,
	input  wire logic [HDL_PORT_W-1:0] response_handle,
	input  wire logic [LEN_W-1:0]      content_length,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [LEN_W-1:0]      cfg_data,
	output logic                       strobe,
	output logic                       kind,
	output logic                       hit,
	output logic [KEY_PORT_W-1:0]      result_key,
	output logic [HDL_PORT_W-1:0]      result_handle,
	output logic [LEN_W-1:0]           free_bytes,
	output logic                       last
);
	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = !busy;

	bwld_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	bwld_datapath #(
		.ENTRIES     (ENTRIES),
		.KEY_BITS    (KEY_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.op              (op),
		.key_tag         (key_tag),
		.response_handle (response_handle),
		.content_length  (content_length),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.strobe          (strobe),
		.kind            (kind),
		.hit             (hit),
		.result_key      (result_key),
		.result_handle   (result_handle),
		.free_bytes      (free_bytes),
		.last            (last)
	);

	// checks
	`BWLD_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
	`BWLD_ASSERT_IMP(a_final_idle, strobe && last, !busy, "final status while still busy")
	`BWLD_ASSERT_IMP(a_notice_busy, strobe && !last, busy, "eviction notice outside an item")
	`BWLD_ASSERT_IMP(a_evict_used, cmd.evict, st.full || st.need_evict, "eviction of empty table")
endmodule
`default_nettype wire

[hdl/bwld_ctrl.sv]
// sequencer of the byte-weighted lru directory
// uses bwld_pkg
`timescale 1ns / 1ps
`default_nettype none
module bwld_ctrl
	import bwld_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  stat_t      st,
	output cmd_t       cmd
);
	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				priority if (!st.is_put)
					state_d = ST_STATUS;
				else if (st.match)
					state_d = ST_UPDATE;
				else if (st.oversize)
					state_d = ST_EVICT;
				else if (st.full)
					state_d = ST_FULLEVICT;
				else
					state_d = ST_INSERT;
			end
			ST_UPDATE:    state_d = ST_EVICT;
			ST_FULLEVICT: state_d = ST_INSERT;
			ST_INSERT:    state_d = ST_EVICT;
			ST_EVICT: begin
				if (!st.need_evict)
					state_d = ST_STATUS;
			end
			ST_STATUS:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_LOOKUP:    cmd.lookup = 1'b1;
			ST_UPDATE:    cmd.update = 1'b1;
			ST_FULLEVICT: cmd.evict  = 1'b1;
			ST_INSERT:    cmd.insert = 1'b1;
			ST_EVICT:     cmd.evict  = st.need_evict;
			ST_STATUS:    cmd.status = 1'b1;
			default:      busy = 1'b1;
		endcase
	end
endmodule
`default_nettype wire

[hdl/bwld_datapath.sv]
// entry store, recency ranks, byte budget and result registers
// uses bwld_pkg
`timescale 1ns / 1ps
`default_nettype none
module bwld_datapath
	import bwld_pkg::*;
#(
	parameter int ENTRIES     = 16,
	parameter int KEY_BITS    = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  cmd_t                       cmd,
	output stat_t                      st,
	input  wire logic [1:0]            op,
	input  wire logic [KEY_PORT_W-1:0] key_tag,
	input  wire logic [HDL_PORT_W-1:0] response_handle,
	input  wire logic [LEN_W-1:0]      content_length,
	input  wire logic                  cfg_we,
	input  wire logic [LEN_W-1:0]      cfg_data,
	output logic                       strobe,
	output logic                       kind,
	output logic                       hit,
	output logic [KEY_PORT_W-1:0]      result_key,
	output logic [HDL_PORT_W-1:0]      result_handle,
	output logic [LEN_W-1:0]           free_bytes,
	output logic                       last
);
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// item registers
	op_t                    op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [LEN_W-1:0]       len_q;

	// entry store
	logic [ENTRIES-1:0]     valid_q;
	logic [KEY_BITS-1:0]    ekey_q [ENTRIES];
	logic [HANDLE_BITS-1:0] ehdl_q [ENTRIES];
	logic [LEN_W-1:0]       elen_q [ENTRIES];
	logic [IW-1:0]          rank_q [ENTRIES];

	logic [CW-1:0]                used_q;
	logic signed [BUDGET_W-1:0]   budget_q;
	logic [LEN_W-1:0]             cap_q;
	logic                         hit_s1;
	logic [IW-1:0]                idx_s1;

	// lookup and free slot search over the lanes
	logic [ENTRIES-1:0] match_vec;
	logic               match_any;
	logic [IW-1:0]      match_idx;
	logic [IW-1:0]      free_idx;
	logic [ENTRIES-1:0] tail_vec;
	logic [IW-1:0]      tail_rank;

	assign tail_rank = IW'(used_q - CW'(1));

	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match_vec[i] = valid_q[i] && (ekey_q[i] == key_q);
			tail_vec[i]  = valid_q[i] && (rank_q[i] == tail_rank);
			if (match_vec[i])
				match_idx = IW'(i);
			if (!valid_q[i])
				free_idx = IW'(i);
		end
		match_any = |match_vec;
	end

	// tail entry, one-hot select
	logic [KEY_BITS-1:0]    tail_key;
	logic [HANDLE_BITS-1:0] tail_hdl;
	logic [LEN_W-1:0]       tail_len;

	always_comb begin
		tail_key = '0;
		tail_hdl = '0;
		tail_len = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			tail_key |= ekey_q[i] & {KEY_BITS{tail_vec[i]}};
			tail_hdl |= ehdl_q[i] & {HANDLE_BITS{tail_vec[i]}};
			tail_len |= elen_q[i] & {LEN_W{tail_vec[i]}};
		end
	end

	logic signed [BUDGET_W-1:0] evict_budget;
	assign evict_budget = budget_q + $signed(BUDGET_W'(tail_len));

	logic oversize;
	assign oversize = len_q > cap_q;

	assign st.is_put     = (op_q == OP_PUT);
	assign st.match      = match_any;
	assign st.oversize   = oversize;
	assign st.full       = (used_q == CW'(ENTRIES));
	assign st.need_evict = (used_q != '0) && (oversize || budget_q < 0);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(op);
			key_q <= key_tag[KEY_BITS-1:0];
			hdl_q <= response_handle[HANDLE_BITS-1:0];
			len_q <= content_length;
		end
		if (cmd.lookup) begin
			hit_s1 <= match_any;
			idx_s1 <= match_idx;
		end
	end

	// promotion of the hit or inserted entry to most recent, and entry writes
	logic          promote;
	logic [IW-1:0] sel_rank;
	assign promote  = cmd.update || (cmd.status && op_q == OP_GET && hit_s1);
	assign sel_rank = rank_q[idx_s1];

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (promote) begin
				if (IW'(i) == idx_s1)
					rank_q[i] <= '0;
				else if (valid_q[i] && rank_q[i] < sel_rank)
					rank_q[i] <= rank_q[i] + IW'(1);
			end else if (cmd.insert) begin
				if (IW'(i) == free_idx)
					rank_q[i] <= '0;
				else if (valid_q[i])
					rank_q[i] <= rank_q[i] + IW'(1);
			end
		end
		if (cmd.update) begin
			ehdl_q[idx_s1] <= hdl_q;
			elen_q[idx_s1] <= len_q;
		end
		if (cmd.insert) begin
			ekey_q[free_idx] <= key_q;
			ehdl_q[free_idx] <= hdl_q;
			elen_q[free_idx] <= len_q;
		end
	end

	// valid bits, fill count, budget and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			used_q   <= '0;
			cap_q    <= CAP_RESET;
			budget_q <= $signed(BUDGET_W'(CAP_RESET));
		end else begin
			priority if (cfg_we) begin
				cap_q    <= cfg_data;
				budget_q <= budget_q + $signed(BUDGET_W'(cfg_data))
					- $signed(BUDGET_W'(cap_q));
			end else if (cmd.update) begin
				budget_q <= budget_q + $signed(BUDGET_W'(elen_q[idx_s1]))
					- $signed(BUDGET_W'(len_q));
			end else if (cmd.insert) begin
				valid_q[free_idx] <= 1'b1;
				used_q            <= used_q + CW'(1);
				budget_q          <= budget_q - $signed(BUDGET_W'(len_q));
			end else if (cmd.evict) begin
				valid_q  <= valid_q & ~tail_vec;
				used_q   <= used_q - CW'(1);
				budget_q <= evict_budget;
			end
		end
	end

	// status handle
	logic                   st_hit;
	logic [HANDLE_BITS-1:0] st_hdl;
	always_comb begin
		st_hit = 1'b0;
		st_hdl = '0;
		unique case (op_q)
			OP_PUT: begin
				st_hit = hit_s1;
				st_hdl = hdl_q;
			end
			OP_PROBE, OP_GET: begin
				st_hit = hit_s1;
				st_hdl = hit_s1 ? ehdl_q[idx_s1] : '0;
			end
			default: begin
				st_hit = 1'b0;
				st_hdl = '0;
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= cmd.evict || cmd.status;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.evict) begin
			kind          <= 1'b0;
			hit           <= 1'b0;
			result_key    <= KEY_PORT_W'(tail_key);
			result_handle <= HDL_PORT_W'(tail_hdl);
			free_bytes    <= sat_free(evict_budget);
			last          <= 1'b0;
		end else if (cmd.status) begin
			kind          <= 1'b1;
			hit           <= st_hit;
			result_key    <= KEY_PORT_W'(key_q);
			result_handle <= HDL_PORT_W'(st_hdl);
			free_bytes    <= sat_free(budget_q);
			last          <= 1'b1;
		end
	end
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for byte_weighted_lru_directory_core
// depends on bwld_pkg and the core; keeps its own recency list and byte budget
`timescale 1ns / 1ps
module tb;
	import bwld_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 24;

	typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_PAUSE} act_t;

	typedef struct {
		act_t        act;
		op_t         op;
		logic [63:0] key;
		logic [15:0] hdl;
		logic [31:0] len;
	} work_t;

	typedef struct {
		logic [63:0] key;
		logic [15:0] hdl;
		logic [31:0] len;
	} line_t;

	typedef struct {
		logic        kind;
		logic        hit;
		logic [63:0] key;
		logic [15:0] hdl;
		logic [31:0] free;
		logic        last;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = OP_PROBE;
	logic [63:0] key_tag = '0;
	logic [15:0] response_handle = '0;
	logic [31:0] content_length = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        strobe;
	logic        kind;
	logic        hit;
	logic [63:0] result_key;
	logic [15:0] result_handle;
	logic [31:0] free_bytes;
	logic        last;

	work_t       work_q[$];
	res_t        pending_results[$];
	line_t       recency_list[$];
	longint      budget;
	logic [31:0] capacity;
	logic [63:0] key_pool[24];
	int          errors = 0;
	int          quiet_cycles = 0;
	int          sent_count = 0;
	int          cycles = 0;
	bit          stim_done = 1'b0;

	byte_weighted_lru_directory_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.key_tag(key_tag), .response_handle(response_handle),
		.content_length(content_length), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .strobe(strobe), .kind(kind), .hit(hit),
		.result_key(result_key), .result_handle(result_handle),
		.free_bytes(free_bytes), .last(last)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// budget clipped to the reporting range
	function automatic logic [31:0] clipped_free();
		if (budget < 0)
			return '0;
		if (budget > 64'sh0_FFFF_FFFF)
			return '1;
		return budget[31:0];
	endfunction

	function automatic void push_result(logic k, logic h, logic [63:0] ky, logic [15:0] hd,
			logic l);
		res_t r;
		r.kind = k; r.hit = h; r.key = ky; r.hdl = hd; r.free = clipped_free(); r.last = l;
		pending_results.push_back(r);
	endfunction

	// drop the least recent line with a notice
	function automatic void evict_oldest();
		line_t e;
		e = recency_list[$];
		recency_list.delete(recency_list.size() - 1);
		budget += longint'(e.len);
		push_result(1'b0, 1'b0, e.key, e.hdl, 1'b0);
	endfunction

	// directory behaviour for one accepted item
	function automatic void apply_request(op_t o, logic [63:0] k, logic [15:0] h,
			logic [31:0] n);
		int    idx;
		line_t e;
		logic  found;
		idx = -1;
		foreach (recency_list[i])
			if (recency_list[i].key == k)
				idx = i;
		found = (idx >= 0);
		case (o)
			OP_PUT: begin
				if (found) begin
					e = recency_list[idx];
					budget += longint'(e.len) - longint'(n);
					recency_list.delete(idx);
					e.hdl = h; e.len = n;
					recency_list.insert(0, e);
				end else if (n <= capacity) begin
					if (recency_list.size() >= DEPTH)
						evict_oldest();
					e.key = k; e.hdl = h; e.len = n;
					recency_list.insert(0, e);
					budget -= longint'(n);
				end
				if (n > capacity) begin
					while (recency_list.size() > 0)
						evict_oldest();
				end else begin
					while (budget < 0 && recency_list.size() > 0)
						evict_oldest();
				end
				push_result(1'b1, found, k, h, 1'b1);
			end
			OP_PROBE, OP_GET: begin
				if (found) begin
					e = recency_list[idx];
					if (o == OP_GET) begin
						recency_list.delete(idx);
						recency_list.insert(0, e);
					end
					push_result(1'b1, 1'b1, k, e.hdl, 1'b1);
				end else
					push_result(1'b1, 1'b0, k, '0, 1'b1);
			end
			default: push_result(1'b1, 1'b0, k, '0, 1'b1);
		endcase
	endfunction

	function automatic void apply_capacity(logic [31:0] v);
		budget += longint'(v) - longint'(capacity);
		capacity = v;
	endfunction

	// stimulus building
	function automatic void add_item(op_t o, logic [63:0] k, logic [15:0] h, logic [31:0] n);
		work_t w;
		w.act = ACT_ITEM; w.op = o; w.key = k; w.hdl = h; w.len = n;
		work_q.push_back(w);
	endfunction

	function automatic void add_ctrl(act_t a, logic [31:0] v);
		work_t w;
		w.act = a; w.op = OP_PROBE; w.key = '0; w.hdl = '0; w.len = v;
		work_q.push_back(w);
	endfunction

	function automatic void add_random(int count, logic [31:0] max_len);
		int          r;
		op_t         o;
		logic [63:0] k;
		logic [31:0] n;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			o = (r < 50) ? OP_PUT : (r < 70) ? OP_PROBE : (r < 95) ? OP_GET : OP_NONE;
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(23)];
			else
				k = {$urandom, $urandom};
			if ($urandom_range(99) < 3)
				n = $urandom;
			else
				n = $urandom_range(max_len);
			add_item(o, k, 16'($urandom), n);
		end
	endfunction

	initial begin
		budget = longint'(CAP_RESET);
		capacity = CAP_RESET;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		// directed part at reset capacity
		add_item(OP_PUT, key_pool[0], 16'h0000, 32'd0);
		add_item(OP_PUT, key_pool[1], 16'hFFFF, CAP_RESET);
		add_item(OP_PROBE, key_pool[1], 16'h1234, 32'd5);
		add_item(OP_GET, key_pool[0], 16'h0000, 32'd0);
		add_item(OP_GET, key_pool[2], 16'h5A5A, 32'd9);
		add_item(OP_NONE, key_pool[1], 16'hFFFF, '1);
		add_item(OP_PUT, key_pool[0], 16'h00FF, 32'd100);
		add_item(OP_PUT, key_pool[3], 16'h0F0F, 32'd200);
		add_item(OP_PUT, key_pool[0], 16'hAAAA, 32'd50);
		add_item(OP_PUT, key_pool[3], 16'h5555, '1);
		add_item(OP_PUT, key_pool[4], 16'h0001, '1);
		for (int i = 0; i < 8; i++)
			add_item(OP_PUT, key_pool[4 + i], 16'($urandom), 32'($urandom_range(1000)));
		// small budget: many evictions, full table
		add_ctrl(ACT_CFG, 32'd2000);
		for (int i = 0; i < 17; i++)
			add_item(OP_PUT, {$urandom, $urandom}, 16'($urandom), 32'd1);
		add_random(60, 32'd400);
		add_ctrl(ACT_PAUSE, '0);
		add_random(30, 32'd400);
		// shrink below what is stored: budget goes negative until the next put
		add_ctrl(ACT_CFG, 32'd300);
		add_item(OP_PROBE, key_pool[2], 16'h0, 32'd0);
		add_item(OP_GET, key_pool[5], 16'h0, 32'd0);
		add_random(20, 32'd150);
		// largest budget
		add_ctrl(ACT_CFG, 32'hFFFF_FFFF);
		add_random(40, 32'hFFFF_FFFF);
		add_ctrl(ACT_CFG, 32'd0);
		add_random(12, 32'd2);
		add_ctrl(ACT_CFG, CAP_RESET);
		add_random(40, 32'h0002_0000);
	end

	// reset
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: single nonblocking update per signal per edge
	always @(posedge clk) begin
		logic  nstart;
		logic  ncfg;
		logic  settled;
		work_t w;
		if (arst_n) begin
			nstart = start;
			ncfg = cfg_valid;
			if (start && !busy) begin
				apply_request(op_t'(op), key_tag, response_handle, content_length);
				sent_count++;
				nstart = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_capacity(cfg_data);
				ncfg = 1'b0;
			end
			settled = (pending_results.size() == 0) && (quiet_cycles >= SETTLE);
			if (!nstart && !ncfg && work_q.size() > 0) begin
				w = work_q[0];
				case (w.act)
					ACT_ITEM: begin
						if ((sent_count >= 100 && sent_count < 160) || $urandom_range(99) >= 16) begin
							void'(work_q.pop_front());
							op <= w.op;
							key_tag <= w.key;
							response_handle <= w.hdl;
							content_length <= w.len;
							nstart = 1'b1;
						end
					end
					ACT_CFG: begin
						if (settled) begin
							void'(work_q.pop_front());
							cfg_data <= w.len;
							ncfg = 1'b1;
						end
					end
					default: begin
						if (settled)
							void'(work_q.pop_front());
					end
				endcase
			end
			if (work_q.size() == 0 && !nstart && !ncfg)
				stim_done <= 1'b1;
			start <= nstart;
			cfg_valid <= ncfg;
		end
	end

	// monitor: results cannot be held off, compare each against oldest prediction
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (strobe) begin
				quiet_cycles <= 0;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t unexpected result kind=%0b key=%h", $time, kind, result_key);
				end else begin
					e = pending_results.pop_front();
					if (e.kind !== kind || e.hit !== hit || e.key !== result_key ||
							e.hdl !== result_handle || e.free !== free_bytes || e.last !== last) begin
						errors++;
						$display("%0t mismatch expected kind=%0b hit=%0b key=%h hdl=%h free=%h last=%0b",
							$time, e.kind, e.hit, e.key, e.hdl, e.free, e.last);
						$display("%0t          actual   kind=%0b hit=%0b key=%h hdl=%h free=%h last=%0b",
							$time, kind, hit, result_key, result_handle, free_bytes, last);
					end
				end
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("[byte_weighted_lru_directory_core] OK");
		else
			$display("[byte_weighted_lru_directory_core] ERROR");
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[byte_weighted_lru_directory_core] ERROR");
			$finish;
		end
	end
endmodule

[byte_weighted_lru_directory_core.f]
+incdir+hdl
hdl/bwld_pkg.sv
hdl/bwld_ctrl.sv
hdl/bwld_datapath.sv
hdl/byte_weighted_lru_directory_core.sv
tb/sv/tb.sv
